[rtl/bcat_pkg.sv]
package bcat_pkg;

	// default sizes
	localparam int unsigned ENTRIES_DEF    = 256;
	localparam int unsigned COUNT_BITS_DEF = 32;

	// operation codes
	localparam logic [1:0] OP_ACCUM = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// result status codes
	localparam logic [2:0] ST_HIT     = 3'd0;
	localparam logic [2:0] ST_NEW     = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_BAD_IDX = 3'd3;
	localparam logic [2:0] ST_OK      = 3'd4;

	// input request
	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  first_char;
		logic [7:0]  second_char;
		logic [31:0] amount;
		logic [7:0]  slot;
	} req_t;

	// result item
	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  entry_index;
		logic [7:0]  entry_first;
		logic [7:0]  entry_second;
		logic [31:0] entry_count;
		logic [8:0]  used_entries;
	} rsp_t;

endpackage

[rtl/bigram_count_accumulator_table.sv]
// Two-byte key count table, entries kept in insertion order.
// Request channel in_valid/in_ready/in_data carries one request (accumulate, read, clear);
// result channel out_valid/out_ready/out_data returns exactly one result per request.
// Keys and counts live in two synchronous single-port-read memories with a registered read.
// Accumulate: a linear search reads one stored key per cycle from entry 0 and stops at the first
// match or after the last stored entry; an empty table goes straight to the append step.
// A hit adds the amount to the count (saturating), a miss appends the key if there is room.
// A read of a stored slot passes through S_RDWAIT; out-of-range reads, clear and unused codes do not.
// One request is in work at a time; in_ready is high only while the engine is idle, so the
// engine returns to idle, and in_ready rises, as a result enters the output register.
// The result sits in an output register: while the receiver stalls, a new request is still
// accepted and processed, and its result waits in a staging register until the output frees.
// Reset clears the fill level and handshake state at once; the memories are not cleared,
// since only entries below the fill level are ever read.
module bigram_count_accumulator_table #(
	parameter int unsigned ENTRIES    = bcat_pkg::ENTRIES_DEF,
	parameter int unsigned COUNT_BITS = bcat_pkg::COUNT_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  bcat_pkg::req_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output bcat_pkg::rsp_t  out_data
);

	localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned FW = $clog2(ENTRIES + 1);
	localparam int unsigned WW = (FW > 8) ? FW : 8;
	localparam int unsigned AW = (COUNT_BITS > 32) ? COUNT_BITS : 32;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SEARCH = 3'd1;
	localparam logic [2:0] S_HIT    = 3'd2;
	localparam logic [2:0] S_APPEND = 3'd3;
	localparam logic [2:0] S_RDWAIT = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [15:0]           key_mem [ENTRIES];
	logic [COUNT_BITS-1:0] cnt_mem [ENTRIES];

	logic [2:0]            state_q;
	logic [FW-1:0]         fill_q;
	logic [IW-1:0]         cmp_q;
	logic [IW-1:0]         hit_idx_q;
	logic [COUNT_BITS-1:0] hit_cnt_q;
	bcat_pkg::req_t        req_q;
	bcat_pkg::rsp_t        res_q;
	logic [15:0]           rd_key_q;
	logic [COUNT_BITS-1:0] rd_cnt_q;
	logic                  out_valid_q;
	bcat_pkg::rsp_t        out_data_q;

	logic [IW-1:0]         rd_addr;
	logic                  out_free;
	logic                  in_acc;
	logic                  slot_ok;
	logic [15:0]           req_key;
	logic [AW-1:0]         amt_w;
	logic [COUNT_BITS-1:0] add_amt;
	logic [COUNT_BITS:0]   sum_w;
	logic [COUNT_BITS-1:0] sat_sum;
	logic                  last_entry;
	bcat_pkg::rsp_t        res_init;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// read range check against the fill level
	assign slot_ok = WW'(in_data.slot) < WW'(fill_q);

	// key and clamped amount of the request in work
	assign req_key = {req_q.first_char, req_q.second_char};
	assign amt_w   = AW'(req_q.amount);
	assign add_amt = (amt_w > AW'(CNT_MAX)) ? CNT_MAX : COUNT_BITS'(amt_w);

	// saturating count update
	assign sum_w   = {1'b0, hit_cnt_q} + {1'b0, add_amt};
	assign sat_sum = sum_w[COUNT_BITS] ? CNT_MAX : sum_w[COUNT_BITS-1:0];

	assign last_entry = (cmp_q == IW'(fill_q - FW'(1)));

	// result defaults taken at acceptance
	always_comb begin
		res_init              = '0;
		res_init.status       = bcat_pkg::ST_BAD_IDX;
		res_init.used_entries = 9'(fill_q);
		if (in_data.op == bcat_pkg::OP_CLEAR) begin
			res_init.status       = bcat_pkg::ST_OK;
			res_init.used_entries = '0;
		end
	end

	// read address: first entry or slot at acceptance, next entry during search
	always_comb begin
		if (state_q == S_IDLE) begin
			rd_addr = (in_data.op == bcat_pkg::OP_READ) ? IW'(in_data.slot) : '0;
		end else begin
			rd_addr = cmp_q + IW'(1);
		end
	end

	// memories: registered read, writes on hit and append
	always_ff @(posedge clk) begin
		rd_key_q <= key_mem[rd_addr];
		rd_cnt_q <= cnt_mem[rd_addr];
		if (state_q == S_HIT) begin
			cnt_mem[hit_idx_q] <= sat_sum;
		end
		if (state_q == S_APPEND && fill_q < FW'(ENTRIES)) begin
			key_mem[IW'(fill_q)] <= req_key;
			cnt_mem[IW'(fill_q)] <= add_amt;
		end
	end

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			fill_q    <= '0;
			cmp_q     <= '0;
			hit_idx_q <= '0;
			hit_cnt_q <= '0;
			req_q     <= '0;
			res_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						req_q <= in_data;
						cmp_q <= '0;
						res_q <= res_init;
						priority if (in_data.op == bcat_pkg::OP_ACCUM) begin
							state_q <= (fill_q == '0) ? S_APPEND : S_SEARCH;
						end else if (in_data.op == bcat_pkg::OP_READ) begin
							state_q <= slot_ok ? S_RDWAIT : S_DONE;
						end else if (in_data.op == bcat_pkg::OP_CLEAR) begin
							fill_q  <= '0;
							state_q <= S_DONE;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SEARCH: begin
					if (rd_key_q == req_key) begin
						hit_idx_q <= cmp_q;
						hit_cnt_q <= rd_cnt_q;
						state_q   <= S_HIT;
					end else if (last_entry) begin
						state_q <= S_APPEND;
					end else begin
						cmp_q <= cmp_q + IW'(1);
					end
				end
				S_HIT: begin
					res_q.status       <= bcat_pkg::ST_HIT;
					res_q.entry_index  <= 8'(hit_idx_q);
					res_q.entry_first  <= req_q.first_char;
					res_q.entry_second <= req_q.second_char;
					res_q.entry_count  <= 32'(sat_sum);
					state_q <= S_DONE;
				end
				S_APPEND: begin
					if (fill_q < FW'(ENTRIES)) begin
						fill_q <= fill_q + FW'(1);
						res_q.status       <= bcat_pkg::ST_NEW;
						res_q.entry_index  <= 8'(fill_q);
						res_q.entry_first  <= req_q.first_char;
						res_q.entry_second <= req_q.second_char;
						res_q.entry_count  <= 32'(add_amt);
						res_q.used_entries <= 9'(fill_q + FW'(1));
					end else begin
						res_q.status <= bcat_pkg::ST_FULL;
					end
					state_q <= S_DONE;
				end
				S_RDWAIT: begin
					res_q.status       <= bcat_pkg::ST_OK;
					res_q.entry_index  <= req_q.slot;
					res_q.entry_first  <= rd_key_q[15:8];
					res_q.entry_second <= rd_key_q[7:0];
					res_q.entry_count  <= 32'(rd_cnt_q);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_data_q <= res_q;
		end
	end

endmodule

[test/tb_top.sv]
module tb_top;

	localparam logic [1:0]  OP_UNUSED       = 2'd3;
	localparam int unsigned TABLE_SIZE      = bcat_pkg::ENTRIES_DEF;
	localparam logic [31:0] COUNT_MAX       = '1;
	localparam int unsigned STALL_LIMIT     = 5000;
	localparam int unsigned ITEMS_PER_PHASE = 110;
	localparam int unsigned MAX_REPORTS     = 10;

	// predicted table contents and the results still owed by the block
	class bigram_tally;
		logic [15:0] keys [TABLE_SIZE];
		logic [31:0] counts [TABLE_SIZE];
		int unsigned used;
		bcat_pkg::rsp_t pending_results [$];
		int unsigned mismatches;

		function new();
			used = 0;
			mismatches = 0;
		endfunction

		// work out the result of one accepted request and update the table
		function void note_request(bcat_pkg::req_t r);
			bcat_pkg::rsp_t e;
			logic [15:0] key;
			logic [32:0] sum;
			int unsigned idx;
			e = '0;
			key = {r.first_char, r.second_char};
			case (r.op)
				bcat_pkg::OP_ACCUM: begin
					idx = 0;
					while (idx < used && keys[idx] != key)
						idx++;
					if (idx < used) begin
						sum = {1'b0, counts[idx]} + {1'b0, r.amount};
						counts[idx] = sum[32] ? COUNT_MAX : sum[31:0];
						e.status = bcat_pkg::ST_HIT;
						e.entry_index = 8'(idx);
						e.entry_first = r.first_char;
						e.entry_second = r.second_char;
						e.entry_count = counts[idx];
					end else if (used < TABLE_SIZE) begin
						keys[used] = key;
						counts[used] = r.amount;
						e.status = bcat_pkg::ST_NEW;
						e.entry_index = 8'(used);
						e.entry_first = r.first_char;
						e.entry_second = r.second_char;
						e.entry_count = r.amount;
						used++;
					end else begin
						e.status = bcat_pkg::ST_FULL;
					end
				end
				bcat_pkg::OP_READ: begin
					if (r.slot < used) begin
						e.status = bcat_pkg::ST_OK;
						e.entry_index = r.slot;
						e.entry_first = keys[r.slot][15:8];
						e.entry_second = keys[r.slot][7:0];
						e.entry_count = counts[r.slot];
					end else begin
						e.status = bcat_pkg::ST_BAD_IDX;
					end
				end
				bcat_pkg::OP_CLEAR: begin
					used = 0;
					e.status = bcat_pkg::ST_OK;
				end
				default: begin
					e.status = bcat_pkg::ST_BAD_IDX;
				end
			endcase
			e.used_entries = 9'(used);
			pending_results.push_back(e);
		endfunction

		// compare one result with the oldest prediction
		function void check_result(bcat_pkg::rsp_t got);
			bcat_pkg::rsp_t e;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: status=%0d index=%0d key=%h%h count=%h used=%0d",
						got.status, got.entry_index, got.entry_first, got.entry_second,
						got.entry_count, got.used_entries);
				return;
			end
			e = pending_results.pop_front();
			if (got.status !== e.status || got.entry_index !== e.entry_index ||
				got.entry_first !== e.entry_first || got.entry_second !== e.entry_second ||
				got.entry_count !== e.entry_count || got.used_entries !== e.used_entries) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("mismatch expected: status=%0d index=%0d key=%h%h count=%h used=%0d",
						e.status, e.entry_index, e.entry_first, e.entry_second,
						e.entry_count, e.used_entries);
					$display("         actual:   status=%0d index=%0d key=%h%h count=%h used=%0d",
						got.status, got.entry_index, got.entry_first, got.entry_second,
						got.entry_count, got.used_entries);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	bcat_pkg::req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	bcat_pkg::rsp_t out_data;

	int unsigned sender_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned quiet_cycles = 0;
	bigram_tally tally = new();

	bigram_count_accumulator_table i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver back-pressure
	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// result check
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tally.check_result(out_data);
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	function automatic bcat_pkg::req_t make_request(logic [1:0] op, logic [7:0] first_char,
		logic [7:0] second_char, logic [31:0] amount, logic [7:0] slot);
		bcat_pkg::req_t r;
		r.op = op;
		r.first_char = first_char;
		r.second_char = second_char;
		r.amount = amount;
		r.slot = slot;
		return r;
	endfunction

	// mostly accumulates on a small key set so hits are common
	function automatic bcat_pkg::req_t random_request();
		bcat_pkg::req_t r;
		logic [7:0] hot_bytes [4];
		int unsigned pick;
		hot_bytes = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
		r.op = bcat_pkg::OP_ACCUM;
		r.first_char = 8'($urandom);
		r.second_char = 8'($urandom);
		r.amount = $urandom;
		r.slot = 8'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 75) begin
			if ($urandom_range(0, 3) != 0) begin
				r.first_char = hot_bytes[$urandom_range(0, 3)];
				r.second_char = 8'($urandom_range(0, 15));
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: r.amount = $urandom_range(0, 1000);
				5, 6:          r.amount = COUNT_MAX - $urandom_range(0, 1000);
				default:       r.amount = $urandom;
			endcase
		end else if (pick < 95) begin
			r.op = bcat_pkg::OP_READ;
			if ($urandom_range(0, 3) != 0)
				r.slot = 8'($urandom_range(0, (tally.used > 255) ? 255 : tally.used));
		end else if (pick < 98) begin
			r.op = bcat_pkg::OP_CLEAR;
		end else begin
			r.op = OP_UNUSED;
		end
		return r;
	endfunction

	// present one request, optionally after idle cycles, and wait for acceptance
	task automatic send_request(input bcat_pkg::req_t r);
		int unsigned gap;
		gap = 0;
		while (gap < 50 && $urandom_range(0, 99) < sender_idle_pct)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		tally.note_request(r);
		@(negedge clk);
	endtask

	// hold off new requests until every result is back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (tally.pending_results.size() != 0)
			@(negedge clk);
	endtask

	// append distinct keys until the table is full, then send hits, misses and a read while full
	task automatic fill_table();
		int unsigned n;
		n = 0;
		while (tally.used < TABLE_SIZE) begin
			send_request(make_request(bcat_pkg::OP_ACCUM, 8'hC0 + 8'(n >> 8), 8'(n), $urandom,
				8'($urandom)));
			n++;
		end
		send_request(make_request(bcat_pkg::OP_ACCUM, 8'hE7, 8'h3C, 32'd9, 8'h00));
		send_request(make_request(bcat_pkg::OP_ACCUM, 8'hC0, 8'h00, 32'd1, 8'h00));
		send_request(make_request(bcat_pkg::OP_READ, 8'h00, 8'h00, 32'd0, 8'hFF));
		send_request(make_request(bcat_pkg::OP_ACCUM, 8'hC0 + 8'(n >> 8), 8'(n), 32'd2, 8'h00));
	endtask

	// stimulus
	initial begin
		int unsigned idle_plan [4];
		int unsigned stall_plan [4];
		idle_plan = '{0, 53, 0, 33};
		stall_plan = '{0, 0, 53, 33};
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty table, saturation, byte-order keys, bounds, unused code, clear
		send_request(make_request(bcat_pkg::OP_READ, 8'h00, 8'h00, 32'd0, 8'h00));
		send_request(make_request(bcat_pkg::OP_CLEAR, 8'hFF, 8'hFF, COUNT_MAX, 8'hFF));
		send_request(make_request(bcat_pkg::OP_ACCUM, 8'h00, 8'h00, 32'd0, 8'h00));
		send_request(make_request(bcat_pkg::OP_ACCUM, 8'hFF, 8'hFF, COUNT_MAX, 8'hFF));
		send_request(make_request(bcat_pkg::OP_ACCUM, 8'hFF, 8'hFF, 32'd1, 8'h00));
		send_request(make_request(bcat_pkg::OP_ACCUM, 8'h00, 8'h00, 32'hFFFF_FFFE, 8'h00));
		send_request(make_request(bcat_pkg::OP_ACCUM, 8'h00, 8'h00, 32'd1, 8'h00));
		send_request(make_request(bcat_pkg::OP_ACCUM, 8'h00, 8'h00, 32'd1, 8'h00));
		send_request(make_request(bcat_pkg::OP_ACCUM, 8'hFF, 8'h00, 32'd5, 8'h00));
		send_request(make_request(bcat_pkg::OP_ACCUM, 8'h00, 8'hFF, 32'd7, 8'h00));
		send_request(make_request(bcat_pkg::OP_READ, 8'hFF, 8'hFF, COUNT_MAX, 8'h00));
		send_request(make_request(bcat_pkg::OP_READ, 8'h00, 8'h00, 32'd0, 8'h01));
		send_request(make_request(bcat_pkg::OP_READ, 8'h00, 8'h00, 32'd0, 8'h03));
		send_request(make_request(bcat_pkg::OP_READ, 8'h00, 8'h00, 32'd0, 8'h04));
		send_request(make_request(bcat_pkg::OP_READ, 8'h00, 8'h00, 32'd0, 8'hFF));
		send_request(make_request(OP_UNUSED, 8'h12, 8'h34, 32'h5555_AAAA, 8'h02));
		send_request(make_request(bcat_pkg::OP_READ, 8'h00, 8'h00, 32'd0, 8'h02));
		send_request(make_request(bcat_pkg::OP_CLEAR, 8'h00, 8'h00, 32'd0, 8'h00));
		send_request(make_request(bcat_pkg::OP_READ, 8'h00, 8'h00, 32'd0, 8'h00));
		send_request(make_request(bcat_pkg::OP_ACCUM, 8'hFF, 8'hFF, 32'd3, 8'h00));
		drain_results();

		// random phases with different idle and stall rates
		for (int p = 0; p < 4; p++) begin
			sender_idle_pct = idle_plan[p];
			stall_pct = stall_plan[p];
			if (p == 0)
				fill_table();
			repeat (ITEMS_PER_PHASE) send_request(random_request());
			drain_results();
		end

		// let any late result show up before the verdict
		stall_pct = 0;
		repeat (TABLE_SIZE + 40) @(negedge clk);
		if (tally.mismatches == 0 && tally.pending_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

[files.f]
rtl/bcat_pkg.sv
rtl/bigram_count_accumulator_table.sv
test/tb_top.sv
